// ----- rtl/ife_pkg.sv -----
// ife_pkg: types, constants and the byte-wide crc-32 step for the index field encoder
// used by ife_ctrl, ife_dp, index_field_encoder and ife_checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ife_pkg;

    localparam int SIZE_W = 63;

    localparam logic [SIZE_W-1:0] USIZE_MIN = 63'd5;
    localparam logic [SIZE_W-1:0] USIZE_MAX = 63'h7FFF_FFFF_FFFF_FFFC;
    localparam logic [31:0]       CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0]       CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [7:0]        BYTE_ZERO = 8'h00;

    // register index, taken from paddr[3]
    localparam logic              REG_RECORD_COUNT = 1'b0;

    typedef struct packed {
        logic              action;
        logic [SIZE_W-1:0] unpad_sz;
        logic [SIZE_W-1:0] raw_sz;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
    } t_out_word;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_RECORDS,
        PH_DONE,
        PH_FAILED
    } t_phase;

    typedef enum logic [1:0] {
        VLI_NONE,
        VLI_COUNT,
        VLI_USZ,
        VLI_CSZ
    } t_vli_src;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_ZERO,
        EMIT_VLI,
        EMIT_CRC,
        EMIT_ERROR
    } t_emit_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_HDR_IND,
        ST_HDR_VLI,
        ST_USZ,
        ST_CSZ,
        ST_PAD,
        ST_CRC,
        ST_ERR
    } t_state;

    typedef struct packed {
        logic      capture;
        t_vli_src  vli_src;
        t_emit_sel emit;
        logic      last;
        logic      phase_wr;
        t_phase    phase_val;
        logic      count_rec;
    } t_dp_cmd;

    typedef struct packed {
        logic can_emit;
        logic vli_final;
        logic dead;
        logic bad;
        logic hdr_pending;
        logic action;
        logic pad_needed;
        logic crc_final;
    } t_dp_stat;

    // one byte through the reflected crc-32, lsb first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/ife_ctrl.sv -----
// ife_ctrl: sequencer for header, record sizes, padding, crc and error words
// depends on ife_pkg; drives ife_dp through t_dp_cmd and reads t_dp_stat
`timescale 1ns / 1ps
`default_nettype none
module ife_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire ife_pkg::t_dp_stat i_stat,
    output ife_pkg::t_dp_cmd       o_cmd
);

    ife_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ife_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_in_ready        = 1'b0;
        o_cmd.capture     = 1'b0;
        o_cmd.vli_src     = ife_pkg::VLI_NONE;
        o_cmd.emit        = ife_pkg::EMIT_NONE;
        o_cmd.last        = 1'b0;
        o_cmd.phase_wr    = 1'b0;
        o_cmd.phase_val   = ife_pkg::PH_FAILED;
        o_cmd.count_rec   = 1'b0;

        unique case (r_state)
            ife_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ife_pkg::ST_DECIDE;
                end
            end
            ife_pkg::ST_DECIDE: begin
                priority if (i_stat.dead) begin
                    n_state = ife_pkg::ST_ERR;
                end else if (i_stat.bad) begin
                    o_cmd.phase_wr  = 1'b1;
                    o_cmd.phase_val = ife_pkg::PH_FAILED;
                    n_state         = ife_pkg::ST_ERR;
                end else begin
                    o_cmd.phase_wr  = 1'b1;
                    o_cmd.phase_val = i_stat.action ? ife_pkg::PH_DONE : ife_pkg::PH_RECORDS;
                    priority if (i_stat.hdr_pending) begin
                        n_state = ife_pkg::ST_HDR_IND;
                    end else if (!i_stat.action) begin
                        o_cmd.vli_src = ife_pkg::VLI_USZ;
                        n_state       = ife_pkg::ST_USZ;
                    end else begin
                        n_state = ife_pkg::ST_PAD;
                    end
                end
            end
            ife_pkg::ST_HDR_IND: begin
                o_cmd.emit = ife_pkg::EMIT_ZERO;
                if (i_stat.can_emit) begin
                    o_cmd.vli_src = ife_pkg::VLI_COUNT;
                    n_state       = ife_pkg::ST_HDR_VLI;
                end
            end
            ife_pkg::ST_HDR_VLI: begin
                o_cmd.emit = ife_pkg::EMIT_VLI;
                if (i_stat.can_emit && i_stat.vli_final) begin
                    if (!i_stat.action) begin
                        o_cmd.vli_src = ife_pkg::VLI_USZ;
                        n_state       = ife_pkg::ST_USZ;
                    end else begin
                        n_state = ife_pkg::ST_PAD;
                    end
                end
            end
            ife_pkg::ST_USZ: begin
                o_cmd.emit = ife_pkg::EMIT_VLI;
                if (i_stat.can_emit && i_stat.vli_final) begin
                    o_cmd.vli_src = ife_pkg::VLI_CSZ;
                    n_state       = ife_pkg::ST_CSZ;
                end
            end
            ife_pkg::ST_CSZ: begin
                o_cmd.emit = ife_pkg::EMIT_VLI;
                o_cmd.last = i_stat.vli_final;
                if (i_stat.can_emit && i_stat.vli_final) begin
                    o_cmd.count_rec = 1'b1;
                    n_state         = ife_pkg::ST_IDLE;
                end
            end
            ife_pkg::ST_PAD: begin
                // re-checked each cycle against the updated byte count
                if (i_stat.pad_needed) begin
                    o_cmd.emit = ife_pkg::EMIT_ZERO;
                end else begin
                    n_state = ife_pkg::ST_CRC;
                end
            end
            ife_pkg::ST_CRC: begin
                o_cmd.emit = ife_pkg::EMIT_CRC;
                o_cmd.last = i_stat.crc_final;
                if (i_stat.can_emit && i_stat.crc_final) begin
                    n_state = ife_pkg::ST_IDLE;
                end
            end
            ife_pkg::ST_ERR: begin
                o_cmd.emit = ife_pkg::EMIT_ERROR;
                o_cmd.last = 1'b1;
                if (i_stat.can_emit) begin
                    n_state = ife_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ife_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/ife_dp.sv -----
// ife_dp: input capture, multibyte integer shifter, crc, counters and output register
// depends on ife_pkg; controlled by ife_ctrl
`timescale 1ns / 1ps
`default_nettype none
module ife_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire ife_pkg::t_dp_cmd           i_cmd,
    output ife_pkg::t_dp_stat               o_stat,
    input  wire ife_pkg::t_in_word          i_in_word,
    input  wire logic [ife_pkg::SIZE_W-1:0] i_record_count,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output ife_pkg::t_out_word              o_out_word
);

    ife_pkg::t_in_word           r_in;
    ife_pkg::t_phase             r_phase;
    logic [31:0]                 r_crc;
    logic [1:0]                  r_bmf;
    logic [1:0]                  r_crc_idx;
    logic [ife_pkg::SIZE_W-1:0]  r_seen;
    logic [ife_pkg::SIZE_W-1:0]  r_vli;
    logic                        r_out_valid;
    ife_pkg::t_out_word          r_out;

    logic                        can_emit;
    logic                        do_emit;
    logic                        data_byte;
    logic [7:0]                  vli_byte;
    logic [31:0]                 crc_fin;
    ife_pkg::t_out_word          word;

    assign can_emit  = !r_out_valid || i_out_ready;
    assign do_emit   = (i_cmd.emit != ife_pkg::EMIT_NONE) && can_emit;
    assign data_byte = do_emit &&
                       (i_cmd.emit == ife_pkg::EMIT_ZERO || i_cmd.emit == ife_pkg::EMIT_VLI);
    assign vli_byte  = {(r_vli[ife_pkg::SIZE_W-1:7] != '0), r_vli[6:0]};
    assign crc_fin   = ~r_crc;

    always_comb begin
        word.last  = i_cmd.last;
        word.error = 1'b0;
        unique case (i_cmd.emit)
            ife_pkg::EMIT_ZERO:  word.out_byte = ife_pkg::BYTE_ZERO;
            ife_pkg::EMIT_VLI:   word.out_byte = vli_byte;
            ife_pkg::EMIT_CRC:   word.out_byte = crc_fin[{r_crc_idx, 3'b000} +: 8];
            ife_pkg::EMIT_ERROR: begin
                word.out_byte = ife_pkg::BYTE_ZERO;
                word.error    = 1'b1;
            end
            default:             word.out_byte = ife_pkg::BYTE_ZERO;
        endcase
    end

    always_comb begin
        o_stat.can_emit    = can_emit;
        o_stat.vli_final   = (r_vli[ife_pkg::SIZE_W-1:7] == '0);
        o_stat.dead        = (r_phase == ife_pkg::PH_DONE) || (r_phase == ife_pkg::PH_FAILED);
        o_stat.hdr_pending = (r_phase == ife_pkg::PH_HEADER);
        o_stat.action      = r_in.action;
        o_stat.pad_needed  = (r_bmf != 2'd0);
        o_stat.crc_final   = (r_crc_idx == 2'd3);
        if (!r_in.action) begin
            o_stat.bad = (r_in.unpad_sz < ife_pkg::USIZE_MIN) ||
                         (r_in.unpad_sz > ife_pkg::USIZE_MAX) ||
                         (r_seen >= i_record_count);
        end else begin
            o_stat.bad = (r_seen != i_record_count);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_word;
        end
        unique case (i_cmd.vli_src)
            ife_pkg::VLI_COUNT: r_vli <= i_record_count;
            ife_pkg::VLI_USZ:   r_vli <= r_in.unpad_sz;
            ife_pkg::VLI_CSZ:   r_vli <= r_in.raw_sz;
            default: begin
                if (do_emit && i_cmd.emit == ife_pkg::EMIT_VLI) begin
                    r_vli <= {7'd0, r_vli[ife_pkg::SIZE_W-1:7]};
                end
            end
        endcase
        if (do_emit) begin
            r_out <= word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ife_pkg::PH_HEADER;
            r_crc       <= ife_pkg::CRC_INIT;
            r_bmf       <= 2'd0;
            r_crc_idx   <= 2'd0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.phase_wr) begin
                r_phase <= i_cmd.phase_val;
            end
            if (data_byte) begin
                r_crc <= ife_pkg::crc_byte(r_crc, word.out_byte);
                r_bmf <= r_bmf + 2'd1;
            end
            if (do_emit && i_cmd.emit == ife_pkg::EMIT_CRC) begin
                r_crc_idx <= r_crc_idx + 2'd1;
            end
            if (i_cmd.count_rec) begin
                r_seen <= r_seen + 1'b1;
            end
            if (do_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
`default_nettype wire

// ----- rtl/index_field_encoder.sv -----
// index field encoder: one word in, index bytes out, one byte per cycle unless stalled
// order: capture of the input word, the decide state, then the first byte registered at the
// output; a finish with no header and no padding passes the pad state before its crc byte;
// a record gives n bytes (up to 28 with the header), a finish pad + 4 crc (+ header) bytes,
// an error one word; a new input word is taken only once the sequencer is back in idle
// reset: i_rst_n synchronous active low; phase to header pending, crc to all ones,
// counters and record_count to zero, output word dropped
`timescale 1ns / 1ps
`default_nettype none
module index_field_encoder (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire ife_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output ife_pkg::t_out_word      o_out_word,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic [63:0]             prdata,
    output logic                    pready
);

    logic [ife_pkg::SIZE_W-1:0] r_record_count;
    ife_pkg::t_dp_cmd           cmd;
    ife_pkg::t_dp_stat          stat;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[3] == ife_pkg::REG_RECORD_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_count <= '0;
        end else if (wr_en) begin
            r_record_count <= pwdata[ife_pkg::SIZE_W-1:0];
        end
    end

    assign prdata = (paddr[3] == ife_pkg::REG_RECORD_COUNT) ? {1'b0, r_record_count} : 64'd0;

    ife_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ife_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_in_word      (i_in_word),
        .i_record_count (r_record_count),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_word     (o_out_word)
    );

endmodule
`default_nettype wire

// ----- rtl/ife_checker.sv -----
// ife_checker: port-level assertions for index_field_encoder, attached by bind
// depends on ife_pkg and the top level's ports
`timescale 1ns / 1ps
`default_nettype none
module ife_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire ife_pkg::t_out_word o_out_word
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // an error word stands alone with a zero byte
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.error |-> o_out_word.last && (o_out_word.out_byte == 8'h00))
        else $error("error word not alone or byte not zero");

    // one word at a time: no new input right after one is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while previous word still in work");

    // no output byte starts while the block has sat idle, ready for input
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && $past(o_in_ready) && o_out_valid && !$past(o_out_valid) |-> 1'b0)
        else $error("byte produced while block idle");

endmodule

bind index_field_encoder ife_checker u_ife_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
`default_nettype wire
